// ===== design/cau_pkg.sv =====
package cau_pkg;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

endpackage

// ===== design/complex_arithmetic_unit_core.sv =====
// Complex add / subtract / multiply / divide on signed fixed-point words.
// A word passes stage 1, stage 2, stage 3 and the restoring divider that retires one quotient
// bit per stage, then the output register that raises the done strobe.
// Throughput: one word per cycle in every mode; busy stays low.
// Reset clears all stage valid bits and the done strobe; the receiver cannot stall.
module complex_arithmetic_unit_core #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  cau_pkg::mode_t               mode,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic                         overflow,
	output logic                         div_zero
);
	import cau_pkg::*;

	localparam int DW  = DATA_WIDTH;
	localparam int PW  = 2 * DW;
	localparam int SW  = 2 * DW + 1;
	localparam int QW  = DW + 1;
	localparam int RW  = 3 * DW + FRAC_BITS + 2;
	localparam int NDS = QW;

	typedef struct packed {
		logic          vld;
		logic          is_div;
		logic          dz;
		logic          neg_re;
		logic          neg_im;
		logic [SW-1:0] mag_re;
		logic [SW-1:0] mag_im;
		logic [RW-1:0] rem_re;
		logic [RW-1:0] rem_im;
		logic [PW-1:0] den;
		logic [QW-1:0] q_re;
		logic [QW-1:0] q_im;
		logic          ovf_re;
		logic          ovf_im;
	} dstage_t;

	assign busy = 1'b0;

	// stage 1: products and add/sub
	logic                 vld_s1;
	mode_t                mode_s1;
	logic signed [PW-1:0] ac_s1, bd_s1, bc_s1, ad_s1, cc_s1, dd_s1;
	logic signed [DW:0]   sre_s1, sim_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		ac_s1   <= PW'(a_re) * PW'(b_re);
		bd_s1   <= PW'(a_im) * PW'(b_im);
		bc_s1   <= PW'(a_im) * PW'(b_re);
		ad_s1   <= PW'(a_re) * PW'(b_im);
		cc_s1   <= PW'(b_re) * PW'(b_re);
		dd_s1   <= PW'(b_im) * PW'(b_im);
		if (mode == MODE_SUB) begin
			sre_s1 <= (DW+1)'(a_re) - (DW+1)'(b_re);
			sim_s1 <= (DW+1)'(a_im) - (DW+1)'(b_im);
		end else begin
			sre_s1 <= (DW+1)'(a_re) + (DW+1)'(b_re);
			sim_s1 <= (DW+1)'(a_im) + (DW+1)'(b_im);
		end
	end

	// stage 2: combine products, divisor
	logic                 vld_s2;
	mode_t                mode_s2;
	logic signed [SW-1:0] vre_s2, vim_s2;
	logic        [PW-1:0] den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		den_s2  <= $unsigned(cc_s1) + $unsigned(dd_s1);
		case (mode_s1)
			MODE_MUL: begin
				vre_s2 <= SW'(ac_s1) - SW'(bd_s1);
				vim_s2 <= SW'(bc_s1) + SW'(ad_s1);
			end
			MODE_DIV: begin
				vre_s2 <= SW'(ac_s1) + SW'(bd_s1);
				vim_s2 <= SW'(bc_s1) - SW'(ad_s1);
			end
			default: begin
				vre_s2 <= SW'(sre_s1);
				vim_s2 <= SW'(sim_s1);
			end
		endcase
	end

	// stage 3: sign-magnitude, divider setup
	dstage_t dv_s [0:NDS];
	dstage_t init_c;
	logic [SW-1:0] mre_c, mim_c;

	always_comb begin
		mre_c = vre_s2[SW-1] ? SW'(-vre_s2) : SW'(vre_s2);
		mim_c = vim_s2[SW-1] ? SW'(-vim_s2) : SW'(vim_s2);
		if (mode_s2 == MODE_MUL) begin
			mre_c = mre_c >> FRAC_BITS;
			mim_c = mim_c >> FRAC_BITS;
		end
		init_c        = '0;
		init_c.vld    = vld_s2;
		init_c.is_div = (mode_s2 == MODE_DIV);
		init_c.dz     = (mode_s2 == MODE_DIV) && (den_s2 == '0);
		init_c.neg_re = vre_s2[SW-1];
		init_c.neg_im = vim_s2[SW-1];
		init_c.mag_re = mre_c;
		init_c.mag_im = mim_c;
		init_c.rem_re = RW'(mre_c) << FRAC_BITS;
		init_c.rem_im = RW'(mim_c) << FRAC_BITS;
		init_c.den    = den_s2;
		// quotient would not fit in QW bits: the divide result saturates unless the divisor is zero
		init_c.ovf_re = (RW'(mre_c) << FRAC_BITS) >= (RW'(den_s2) << QW);
		init_c.ovf_im = (RW'(mim_c) << FRAC_BITS) >= (RW'(den_s2) << QW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= '0;
		end else begin
			dv_s[0] <= init_c;
		end
	end

	// restoring divider, one quotient bit per stage, MSB first
	for (genvar g = 1; g <= NDS; g++) begin : g_div
		localparam int BIT = NDS - g;
		dstage_t       nxt_c;
		logic [RW-1:0] dsh_c;

		always_comb begin
			nxt_c = dv_s[g-1];
			dsh_c = RW'(dv_s[g-1].den) << BIT;
			if (dv_s[g-1].rem_re >= dsh_c) begin
				nxt_c.rem_re   = dv_s[g-1].rem_re - dsh_c;
				nxt_c.q_re[BIT] = 1'b1;
			end
			if (dv_s[g-1].rem_im >= dsh_c) begin
				nxt_c.rem_im   = dv_s[g-1].rem_im - dsh_c;
				nxt_c.q_im[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[g] <= '0;
			end else begin
				dv_s[g] <= nxt_c;
			end
		end
	end

	// saturation and output word
	function automatic logic [DW:0] sat(input logic neg, input logic [SW-1:0] mag);
		logic [DW:0] r;
		r = '0;
		if (mag == '0) begin
			r = '0;
		end else if (neg) begin
			if (mag > (SW'(1) << (DW - 1))) begin
				r = {1'b1, 1'b1, {(DW-1){1'b0}}};
			end else begin
				r = {1'b0, DW'(-mag)};
			end
		end else begin
			if (mag > ((SW'(1) << (DW - 1)) - SW'(1))) begin
				r = {1'b1, 1'b0, {(DW-1){1'b1}}};
			end else begin
				r = {1'b0, DW'(mag)};
			end
		end
		return r;
	endfunction

	dstage_t       fin;
	logic [SW-1:0] fre_c, fim_c;
	logic [DW:0]   sre_c, sim_c;

	always_comb begin
		fin = dv_s[NDS];
		if (fin.is_div) begin
			fre_c = fin.ovf_re ? (SW'(1) << DW) : SW'(fin.q_re);
			fim_c = fin.ovf_im ? (SW'(1) << DW) : SW'(fin.q_im);
		end else begin
			fre_c = fin.mag_re;
			fim_c = fin.mag_im;
		end
		sre_c = sat(fin.neg_re, fre_c);
		sim_c = sat(fin.neg_im, fim_c);
	end

	logic          done_q, ovf_q, dz_q;
	logic [DW-1:0] res_re_q, res_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.dz) begin
			res_re_q <= '0;
			res_im_q <= '0;
			ovf_q    <= 1'b0;
			dz_q     <= 1'b1;
		end else begin
			res_re_q <= sre_c[DW-1:0];
			res_im_q <= sim_c[DW-1:0];
			ovf_q    <= sre_c[DW] | sim_c[DW];
			dz_q     <= 1'b0;
		end
	end

	assign done     = done_q;
	assign res_re   = res_re_q;
	assign res_im   = res_im_q;
	assign overflow = ovf_q;
	assign div_zero = dz_q;

	a_done_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(dv_s[NDS].vld))
		else $error("done without a word in the last stage");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_zero) |-> (res_re == '0 && res_im == '0 && !overflow))
		else $error("divide by zero word has nonzero parts or overflow");

	a_ovf_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |->
		(res_re[DW-2:0] == '0 && res_re[DW-1]) || (res_re[DW-2:0] == '1 && !res_re[DW-1]) ||
		(res_im[DW-2:0] == '0 && res_im[DW-1]) || (res_im[DW-2:0] == '1 && !res_im[DW-1]))
		else $error("overflow flagged without a saturated part");

	a_dz_div_only: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_s[0].vld && dv_s[0].dz) |-> dv_s[0].is_div)
		else $error("zero divisor flagged outside divide");

endmodule
